[rtl/core/dtr_pkg.sv]
`default_nettype none
package dtr_pkg;

  localparam int unsigned NORMAL_FRAC_BITS = 14;
  localparam int unsigned NORMAL_W = 16;
  localparam int unsigned PERM_W = 32;
  localparam int unsigned OUT_W = 33;

  localparam int unsigned QW = NORMAL_W + 1;
  localparam int unsigned SQ_W = 2 * QW;
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned RF = 30;
  localparam int unsigned PF = 29;
  localparam int unsigned R_W = RF + 2;
  localparam int unsigned DIV_STAGES = RF + 2;
  localparam int unsigned RR_W = 2 * R_W;
  localparam int unsigned RR_SHIFT = 2 * RF - PF;
  localparam int unsigned P_W = 32;
  localparam int unsigned KP_W = 64;

  localparam int unsigned IN_DATA_W = 144;
  localparam int unsigned OUT_DATA_W = 200;

  localparam logic signed [OUT_W+1:0] OUT_MAX = 35'sh0_FFFF_FFFF;
  localparam logic signed [OUT_W+1:0] OUT_MIN = -35'sh1_0000_0000;

  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic [2:0][PERM_W-1:0] k;
  } side_t;

endpackage
`default_nettype wire

[rtl/core/dtr_div.sv]
`default_nettype none
module dtr_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic signed [dtr_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire logic        [dtr_pkg::DIV_DEN_W-1:0]  den_i,
  output logic signed      [dtr_pkg::R_W-1:0]        quo_o
);
  import dtr_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [RF+1];
  logic [DIV_DEN_W-1:0] den_q [RF+1];
  logic [RF:0]          quo_q [RF+1];
  logic                 neg_q [RF+1];
  logic signed [R_W-1:0] quo_out_q;

  for (genvar i = 0; i <= RF; i++) begin : g_step
    logic [DIV_DEN_W:0]   t;
    logic [DIV_DEN_W-1:0] d;
    logic [RF:0]          q;
    logic                 n;
    logic                 ge;
    if (i == 0) begin : g_first
      always_comb begin
        t = num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
        d = den_i;
        q = '0;
        n = num_i[DIV_NUM_W-1];
      end
    end else begin : g_next
      always_comb begin
        t = {rem_q[i-1], 1'b0};
        d = den_q[i-1];
        q = quo_q[i-1];
        n = neg_q[i-1];
      end
    end
    assign ge = t >= {1'b0, d};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? DIV_DEN_W'(t - {1'b0, d}) : t[DIV_DEN_W-1:0];
        den_q[i] <= d;
        quo_q[i] <= {q[RF-1:0], ge};
        neg_q[i] <= n;
      end
    end
  end

  logic [R_W-1:0] mag;
  assign mag = {1'b0, quo_q[RF]} +
               R_W'({rem_q[RF], 1'b0} >= {1'b0, den_q[RF]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_out_q <= neg_q[RF] ? -$signed(mag) : $signed(mag);
    end
  end

  assign quo_o = quo_out_q;

endmodule
`default_nettype wire

[rtl/core/diagonal_tensor_rotation.sv]
`default_nettype none
// channel  dir  tdata                                          tuser
// s_axis   in   normal x,y,z (16 each), perm x,y,z (32 each)  -
// m_axis   out  tensor xx,xy,xz,yy,yz,zz (33 each)            degenerate
//
// One word enters every cycle while the output side takes words.
// The depth is set by the 32-stage dividers: 31 quotient bits, one per stage, then rounding.
// The whole pipe holds when the output register is full and not taken.
// Reset clears the valid bits and side-band registers only.
module diagonal_tensor_rotation (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // normal_x, normal_y, normal_z, perm_principal_x, perm_principal_y, perm_principal_z
  input  wire logic [dtr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz, zero pad
  output logic [dtr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // degenerate
  output logic [0:0]                            m_axis_tuser
);
  import dtr_pkg::*;

  localparam logic [11:0] PI_IDX = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [11:0] PJ_IDX = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  side_t side1_q, side2_q, side3_q, side_rr_q, side_p_q, side_kp_q, side_acc_q;
  side_t side_div_q [DIV_STAGES];
  side_t side_in;

  logic signed [QW-1:0] nx, ny, nz;
  assign nx = QW'($signed(s_axis_tdata[15:0]));
  assign ny = QW'($signed(s_axis_tdata[31:16]));
  assign nz = QW'($signed(s_axis_tdata[47:32]));

  always_comb begin
    side_in.vld   = s_axis_tvalid;
    side_in.degen = 1'b0;
    side_in.k[0]  = s_axis_tdata[79:48];
    side_in.k[1]  = s_axis_tdata[111:80];
    side_in.k[2]  = s_axis_tdata[143:112];
  end

  logic signed [QW-1:0] a_q, b_q, w_q;
  logic signed [SQ_W-1:0] a2_q, b2_q, w2_q, ab_q, wb_q, wa_q;
  logic [DIV_DEN_W-1:0] n_q;
  logic signed [DIV_NUM_W-1:0] m_q [6];

  logic signed [SQ_W-1:0] a2_d, b2_d, w2_d, ab_d, wb_d, wa_d;
  assign a2_d = a_q * a_q;
  assign b2_d = b_q * b_q;
  assign w2_d = w_q * w_q;
  assign ab_d = a_q * b_q;
  assign wb_d = w_q * b_q;
  assign wa_d = w_q * a_q;

  logic signed [SQ_W:0] n_d, m0_d, m4_d, m8_d;
  assign n_d  = SQ_W'(a2_q) + b2_q + w2_q;
  assign m0_d = w2_q + SQ_W'(a2_q) - b2_q;
  assign m4_d = w2_q - SQ_W'(a2_q) + b2_q;
  assign m8_d = w2_q - SQ_W'(a2_q) - b2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= -ny;
      b_q  <= nx;
      w_q  <= QW'(1 << NORMAL_FRAC_BITS) - nz;
      a2_q <= a2_d;
      b2_q <= b2_d;
      w2_q <= w2_d;
      ab_q <= ab_d;
      wb_q <= wb_d;
      wa_q <= wa_d;
      n_q  <= n_d[DIV_DEN_W-1:0];
      m_q[0] <= m0_d[DIV_NUM_W-1:0];
      m_q[1] <= DIV_NUM_W'(ab_q) <<< 1;
      m_q[2] <= DIV_NUM_W'(wb_q) <<< 1;
      m_q[3] <= m4_d[DIV_NUM_W-1:0];
      m_q[4] <= DIV_NUM_W'(wa_q) <<< 1;
      m_q[5] <= m8_d[DIV_NUM_W-1:0];
    end
  end

  logic signed [R_W-1:0] q_s [6];
  for (genvar g = 0; g < 6; g++) begin : g_div
    dtr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (m_q[g]),
      .den_i (n_q),
      .quo_o (q_s[g])
    );
  end

  logic signed [R_W-1:0] r_s [9];
  assign r_s[0] = q_s[0];
  assign r_s[1] = q_s[1];
  assign r_s[2] = q_s[2];
  assign r_s[3] = q_s[1];
  assign r_s[4] = q_s[3];
  assign r_s[5] = -q_s[4];
  assign r_s[6] = -q_s[2];
  assign r_s[7] = q_s[4];
  assign r_s[8] = q_s[5];

  logic signed [RR_W-1:0] rr_q  [6][3];
  logic signed [P_W-1:0]  p_q   [6][3];
  logic signed [KP_W-1:0] kp_q  [6][3];
  logic signed [KP_W-1:0] acc_q [6];
  logic signed [OUT_W-1:0] t_q  [6];
  logic degen_q;

  for (genvar e = 0; e < 6; e++) begin : g_ent
    for (genvar l = 0; l < 3; l++) begin : g_row
      localparam int unsigned IA = l * 3 + int'(PI_IDX[2*e +: 2]);
      localparam int unsigned IB = l * 3 + int'(PJ_IDX[2*e +: 2]);
      logic signed [RR_W-1:0] rr_d;
      logic signed [RR_W-1:0] rr_bias;
      logic signed [P_W+P_W:0] kp_d;
      assign rr_d = r_s[IA] * r_s[IB];
      assign rr_bias = rr_q[e][l] + RR_W'(64'sd1 <<< (RR_SHIFT - 1))
                       - RR_W'(rr_q[e][l][RR_W-1]);
      assign kp_d = $signed({1'b0, side_p_q.k[l]}) * p_q[e][l];
      always_ff @(posedge clk_i) begin
        if (en) begin
          rr_q[e][l] <= rr_d;
          p_q[e][l]  <= P_W'(rr_bias >>> RR_SHIFT);
          kp_q[e][l] <= kp_d[KP_W-1:0];
        end
      end
    end

    logic signed [KP_W-1:0] acc_bias;
    logic signed [OUT_W+1:0] rnd;
    logic signed [OUT_W-1:0] sat;
    assign acc_bias = acc_q[e] + KP_W'(64'sd1 <<< (PF - 1)) - KP_W'(acc_q[e][KP_W-1]);
    assign rnd = (OUT_W + 2)'(acc_bias >>> PF);
    always_comb begin
      if (rnd > OUT_MAX) begin
        sat = OUT_MAX[OUT_W-1:0];
      end else if (rnd < OUT_MIN) begin
        sat = OUT_MIN[OUT_W-1:0];
      end else begin
        sat = rnd[OUT_W-1:0];
      end
    end

    logic signed [OUT_W-1:0] pass;
    if (e == 0) begin : g_pxx
      assign pass = $signed({1'b0, side_acc_q.k[0]});
    end else if (e == 3) begin : g_pyy
      assign pass = $signed({1'b0, side_acc_q.k[1]});
    end else if (e == 5) begin : g_pzz
      assign pass = $signed({1'b0, side_acc_q.k[2]});
    end else begin : g_poff
      assign pass = '0;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        acc_q[e] <= kp_q[e][0] + kp_q[e][1] + kp_q[e][2];
        t_q[e]   <= side_acc_q.degen ? pass : sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q    <= '0;
      side2_q    <= '0;
      side3_q    <= '0;
      side_rr_q  <= '0;
      side_p_q   <= '0;
      side_kp_q  <= '0;
      side_acc_q <= '0;
      for (int i = 0; i < int'(DIV_STAGES); i++) begin
        side_div_q[i] <= '0;
      end
      out_vld_q  <= 1'b0;
      degen_q    <= 1'b0;
    end else if (en) begin
      side1_q       <= side_in;
      side2_q       <= '{vld: side1_q.vld,
                         degen: (a_q == '0) && (b_q == '0) && (w_q == '0),
                         k: side1_q.k};
      side3_q       <= side2_q;
      side_div_q[0] <= side3_q;
      for (int i = 1; i < int'(DIV_STAGES); i++) begin
        side_div_q[i] <= side_div_q[i-1];
      end
      side_rr_q  <= side_div_q[DIV_STAGES-1];
      side_p_q   <= side_rr_q;
      side_kp_q  <= side_p_q;
      side_acc_q <= side_kp_q;
      out_vld_q  <= side_acc_q.vld;
      degen_q    <= side_acc_q.degen;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, t_q[5], t_q[4], t_q[3], t_q[2], t_q[1], t_q[0]};
  assign m_axis_tuser  = degen_q;

  a_degen_offdiag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (t_q[1] == '0 && t_q[2] == '0 && t_q[4] == '0))
    else $error("degenerate word with nonzero off-diagonal entry");

  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!t_q[0][OUT_W-1] && !t_q[3][OUT_W-1] && !t_q[5][OUT_W-1]))
    else $error("negative diagonal entry");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

[verif/diagonal_tensor_rotation_tb.sv]
`timescale 1ns / 1ps
module diagonal_tensor_rotation_tb;
  import dtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic signed [15:0] ONE = 16'sd16384;

  typedef struct packed {
    logic [5:0][OUT_W-1:0] t;
    logic                  degen;
  } tensor_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  tensor_word_t tensor_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  words_sent = 0;
  int unsigned  degen_sent = 0;
  int unsigned  words_seen = 0;
  int unsigned  stall_left = 0;
  bit           idle_en = 1'b1;
  string        field_name[6] = '{"tensor_xx", "tensor_xy", "tensor_xz",
                                  "tensor_yy", "tensor_yz", "tensor_zz"};

  diagonal_tensor_rotation uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint rot_coef(longint m, longint n);
    bit neg;
    longint unsigned r, d, q;
    neg = m < 0;
    r = neg ? -m : m;
    d = n;
    q = 0;
    for (int i = 0; i <= RF; i++) begin
      if (i > 0) r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if ((r << 1) >= d) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_shift(longint v, int s);
    bit neg;
    longint unsigned m;
    neg = v < 0;
    m = neg ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(longint v);
    if (v > 64'sd4294967295) v = 64'sd4294967295;
    if (v < -64'sd4294967296) v = -64'sd4294967296;
    return v[OUT_W-1:0];
  endfunction

  function automatic tensor_word_t predict_tensor(logic [IN_DATA_W-1:0] w);
    tensor_word_t res;
    longint nx, ny, nz, a, b, c, n, acc, p;
    longint k[3];
    longint mm[9];
    longint r[9];
    int ri[6] = '{0, 0, 0, 1, 1, 2};
    int rj[6] = '{0, 1, 2, 1, 2, 2};
    nx = longint'($signed(w[15:0]));
    ny = longint'($signed(w[31:16]));
    nz = longint'($signed(w[47:32]));
    for (int l = 0; l < 3; l++) k[l] = longint'({32'd0, w[48+32*l +: 32]});
    a = -ny;
    b = nx;
    c = (64'sd1 << NORMAL_FRAC_BITS) - nz;
    n = a * a + b * b + c * c;
    res = '0;
    if (n == 0) begin
      res.t[0] = clamp_out(k[0]);
      res.t[3] = clamp_out(k[1]);
      res.t[5] = clamp_out(k[2]);
      res.degen = 1'b1;
      return res;
    end
    mm[0] = c * c + a * a - b * b;
    mm[1] = 2 * a * b;
    mm[2] = 2 * c * b;
    mm[3] = 2 * a * b;
    mm[4] = c * c - a * a + b * b;
    mm[5] = -2 * c * a;
    mm[6] = -2 * c * b;
    mm[7] = 2 * c * a;
    mm[8] = c * c - a * a - b * b;
    for (int e = 0; e < 9; e++) r[e] = rot_coef(mm[e], n);
    for (int e = 0; e < 6; e++) begin
      acc = 0;
      for (int l = 0; l < 3; l++) begin
        p = round_shift(r[l*3+ri[e]] * r[l*3+rj[e]], RR_SHIFT);
        acc += k[l] * p;
      end
      res.t[e] = clamp_out(round_shift(acc, PF));
    end
    return res;
  endfunction

  task automatic send_word(logic signed [15:0] nx, logic signed [15:0] ny,
                           logic signed [15:0] nz, logic [31:0] kx,
                           logic [31:0] ky, logic [31:0] kz);
    int unsigned gap;
    logic [IN_DATA_W-1:0] w;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    w = {kz, ky, kx, nz, ny, nx};
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tensor_q.insert(tensor_q.size(), predict_tensor(w));
    words_sent++;
    if (nx == 0 && ny == 0 && nz == ONE) degen_sent++;
  endtask

  function automatic logic [15:0] near_one();
    return ONE + 16'($signed($urandom_range(0, 64)) - 32);
  endfunction

  task automatic test_directed();
    send_word(0, 0, 0, 0, 0, 0);
    send_word(0, 0, ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(0, 0, ONE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_word(0, 0, -ONE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_word(ONE, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_word(0, ONE, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_word(-ONE, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_word(0, -ONE, 0, 0, 32'hFFFF_FFFF, 0);
    send_word(0, 0, ONE - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(0, 0, ONE + 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_word(1, 0, ONE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    send_word(0, -1, ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 32'h0000_0001, 32'h8000_0000, 0);
    send_word(11585, 0, 11585, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(0, 11585, -11585, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_word(9459, -9459, 9459, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(-9459, 9459, -9459, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_degenerate();
    repeat (10) send_word(0, 0, ONE, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [31:0] rand_perm();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int unsigned count);
    logic signed [15:0] v[3];
    int unsigned ax;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          foreach (v[i]) v[i] = 16'($urandom);
        end
        2: begin
          v[0] = 0;
          v[1] = 0;
          v[2] = ($urandom_range(0, 1)) ? ONE : near_one();
        end
        3: begin
          v[0] = 16'($signed($urandom_range(0, 4)) - 2);
          v[1] = 16'($signed($urandom_range(0, 4)) - 2);
          v[2] = ONE;
        end
        default: begin
          ax = $urandom_range(0, 2);
          foreach (v[i]) v[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
          v[ax] = ($urandom_range(0, 1)) ? near_one() : -near_one();
        end
      endcase
      send_word(v[0], v[1], v[2], rand_perm(), rand_perm(), rand_perm());
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    test_random(80);
  endtask

  always @(posedge clk_i) begin
    tensor_word_t exp_w;
    logic [OUT_W-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (tensor_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_w = tensor_q.pop_front();
        for (int e = 0; e < 6; e++) begin
          got = m_axis_tdata[e*OUT_W +: OUT_W];
          if (got !== exp_w.t[e]) begin
            $error("%s expected %h actual %h", field_name[e], exp_w.t[e], got);
            errors++;
          end
        end
        if (m_axis_tuser[0] !== exp_w.degen) begin
          $error("degenerate expected %b actual %b", exp_w.degen, m_axis_tuser[0]);
          errors++;
        end
      end
    end
    if (!idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 6) == 0) stall_left <= $urandom_range(1, 11);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** diagonal_tensor_rotation: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_degenerate();
    test_random(440);
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (tensor_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d words (%0d degenerate normals), checked %0d results",
             words_sent, degen_sent, words_seen);
    $display("covered field extremes, axis normals, random and near-unit normals");
    if (errors == 0) begin
      $display("** diagonal_tensor_rotation: PASSED **");
    end else begin
      $display("** diagonal_tensor_rotation: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dtr_pkg.sv
rtl/core/dtr_div.sv
rtl/core/diagonal_tensor_rotation.sv
verif/diagonal_tensor_rotation_tb.sv
